@@ rtl/core/cfgc_pkg.sv @@
// Shared types, constants and the CRC byte update for the CRC-32 FCS generator/checker.
package cfgc_pkg;

	localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_TOPBIT = 32'h8000_0000;

	// Trailing FCS length in bytes; also the depth of the verify delay line
	localparam int unsigned FCS_BYTES = 4;
	localparam int unsigned CNT_W     = $clog2(FCS_BYTES + 1);

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_VALID   = 2'd1,
		ST_CORRUPT = 2'd2,
		ST_SHORT   = 2'd3
	} check_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0]    out_byte;
		logic          is_fcs;
		logic          last_out;
		check_status_t check_status;
		logic [31:0]   computed_crc;
		logic [31:0]   received_fcs;
	} result_beat_t;

	// Input register contents handed to the frame core
	typedef struct packed {
		logic       valid;
		byte_beat_t beat;
	} stage_t;

	// One byte of MSB-first CRC, unrolled over eight bit steps
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOPBIT) != 32'h0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/cfgc_byte_if.sv @@
// Byte input channel: valid/ready with one frame byte and its end-of-frame mark.
interface cfgc_byte_if import cfgc_pkg::*; ();
	logic       valid;
	logic       ready;
	byte_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/cfgc_result_if.sv @@
// Result channel: valid/ready with one output beat.
interface cfgc_result_if import cfgc_pkg::*; ();
	logic         valid;
	logic         ready;
	result_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/cfgc_cfg_if.sv @@
// Configuration write channel carrying the check_mode bit.
interface cfgc_cfg_if import cfgc_pkg::*; ();
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/cfgc_in_stage.sv @@
// Input register: captures one byte beat, frees when the core takes it.
module cfgc_in_stage import cfgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cfgc_byte_if.sink   byte_ch,
	input  logic        take,
	output stage_t      s1
);

	logic       valid_s1;
	byte_beat_t beat_s1;

	// Accept when empty or when the held beat leaves this cycle
	assign byte_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			beat_s1 <= byte_ch.payload;
		end
	end

	assign s1 = '{valid: valid_s1, beat: beat_s1};

endmodule

@@ rtl/core/cfgc_frame_core.sv @@
// Frame core: CRC state, verify delay line, FCS append sequencer and result register.
module cfgc_frame_core import cfgc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cfgc_cfg_if.sink      cfg_ch,
	input  stage_t        s1,
	output logic          take,
	cfgc_result_if.source result_ch
);

	logic                check_mode_q;
	logic [31:0]         crc_q;
	logic [7:0]          tail_q [FCS_BYTES];
	logic [CNT_W-1:0]    held_q;
	logic [CNT_W-1:0]    fcs_cnt_q;
	logic [31:0]         fcs_shift_q;
	logic [31:0]         fin_q;
	logic                out_valid_q;
	result_beat_t        out_beat_q;

	logic                slot_free;
	logic                fcs_busy;
	logic                held_full;
	logic [7:0]          upd_byte;
	logic [31:0]         crc_upd;
	logic [31:0]         crc_next;
	logic [31:0]         fin_next;
	logic [CNT_W-1:0]    held_next;
	logic [7:0]          tail_next [FCS_BYTES];
	logic [31:0]         recv;
	logic                emit;
	result_beat_t        beat_n;

	// Config register, always ready
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			check_mode_q <= cfg_ch.data;
		end
	end

	// Handshake: output slot free, FCS bytes go ahead of new input
	assign slot_free = !out_valid_q || result_ch.ready;
	assign fcs_busy  = fcs_cnt_q != '0;
	assign take      = slot_free && !fcs_busy && s1.valid;

	// Shared CRC update: input byte in generate, oldest delayed byte in verify
	assign held_full = held_q >= CNT_W'(FCS_BYTES);
	assign upd_byte  = check_mode_q ? tail_q[0] : s1.beat.data_byte;
	assign crc_upd   = crc_byte(crc_q, upd_byte);
	assign crc_next  = (!check_mode_q || held_full) ? crc_upd : crc_q;
	assign fin_next  = crc_next ^ CRC_XOROUT;
	assign held_next = held_full ? CNT_W'(FCS_BYTES) : held_q + CNT_W'(1);

	// Delay line shifted by one byte
	always_comb begin
		for (int i = 0; i < FCS_BYTES - 1; i++) begin
			tail_next[i] = tail_q[i + 1];
		end
		tail_next[FCS_BYTES - 1] = s1.beat.data_byte;
	end

	always_comb begin
		recv = '0;
		for (int i = 0; i < FCS_BYTES; i++) begin
			recv = {recv[23:0], tail_next[i]};
		end
	end

	// Next result beat
	always_comb begin
		beat_n = '0;
		emit   = 1'b0;
		if (fcs_busy) begin
			emit            = 1'b1;
			beat_n.out_byte = fcs_shift_q[31:24];
			beat_n.is_fcs   = 1'b1;
			if (fcs_cnt_q == CNT_W'(1)) begin
				beat_n.last_out     = 1'b1;
				beat_n.computed_crc = fin_q;
			end
		end else if (take) begin
			if (!check_mode_q) begin
				emit            = 1'b1;
				beat_n.out_byte = s1.beat.data_byte;
			end else if (s1.beat.frame_end) begin
				emit            = 1'b1;
				beat_n.last_out = 1'b1;
				if (!held_full && held_next < CNT_W'(FCS_BYTES)) begin
					beat_n.check_status = ST_SHORT;
				end else begin
					beat_n.check_status = (fin_next == recv) ? ST_VALID : ST_CORRUPT;
					beat_n.computed_crc = fin_next;
					beat_n.received_fcs = recv;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			out_beat_q <= beat_n;
		end
	end

	assign result_ch.valid   = out_valid_q;
	assign result_ch.payload = out_beat_q;

	// FCS append sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcs_cnt_q <= '0;
		end else if (slot_free) begin
			if (fcs_busy) begin
				fcs_cnt_q <= fcs_cnt_q - CNT_W'(1);
			end else if (take && !check_mode_q && s1.beat.frame_end) begin
				fcs_cnt_q <= CNT_W'(FCS_BYTES);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (fcs_busy) begin
				fcs_shift_q <= {fcs_shift_q[23:0], 8'h00};
			end else if (take && !check_mode_q && s1.beat.frame_end) begin
				fcs_shift_q <= fin_next;
				fin_q       <= fin_next;
			end
		end
	end

	// Frame state: cleared at every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			held_q <= '0;
			for (int i = 0; i < FCS_BYTES; i++) begin
				tail_q[i] <= 8'h00;
			end
		end else if (take) begin
			if (s1.beat.frame_end) begin
				crc_q  <= CRC_INIT;
				held_q <= '0;
				for (int i = 0; i < FCS_BYTES; i++) begin
					tail_q[i] <= 8'h00;
				end
			end else begin
				crc_q <= crc_next;
				if (check_mode_q) begin
					held_q <= held_next;
					for (int i = 0; i < FCS_BYTES; i++) begin
						tail_q[i] <= tail_next[i];
					end
				end
			end
		end
	end

endmodule

@@ rtl/core/crc32_frame_fcs_gen_check.sv @@
// Top level of the CRC-32 frame FCS generator and checker.
//
// Channels: byte_ch takes frame bytes with a frame_end mark; result_ch delivers
// result beats; cfg_ch writes check_mode (0 generate, 1 verify) while idle.
// The CRC is MSB-first, polynomial 04C11DB7, init and final XOR FFFFFFFF.
// Generate: each byte comes back as one beat; after the last byte four FCS
// beats follow, most significant byte first, the last one with last_out set.
// Verify: no beat per byte; at frame end one status beat (valid, corrupted,
// too short), with the computed CRC and the received FCS unless too short.
// The user must write check_mode only while idle; the block does not enforce it.
// A byte's beat passes through the input register, then the result register.
// Throughput: one byte per cycle unless result_ch stalls; a generate-mode frame
// end holds input while the FCS beats go out from the result register.
// The CRC update is one unrolled byte step between those two registers.
// Reset inits the CRC and clears the delay line, counters and check_mode (generate).
// When result_ch stalls, the result register holds and the input register
// takes at most one more byte before byte_ch.ready drops.
module crc32_frame_fcs_gen_check import cfgc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cfgc_cfg_if.sink      cfg_ch,
	cfgc_byte_if.sink     byte_ch,
	cfgc_result_if.source result_ch
);

	stage_t s1;
	logic   take;

	cfgc_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.take    (take),
		.s1      (s1)
	);

	cfgc_frame_core u_frame_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_ch    (cfg_ch),
		.s1        (s1),
		.take      (take),
		.result_ch (result_ch)
	);

endmodule

@@ rtl/core/cfgc_checker.sv @@
// Port-level checker for the CRC-32 FCS block, bound to the top level.
module cfgc_checker import cfgc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         out_valid,
	input logic         out_ready,
	input result_beat_t out_beat
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("result beat changed while stalled");

	// FCS bytes follow each other until the last one
	a_fcs_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.is_fcs && !out_beat.last_out |=> out_valid && out_beat.is_fcs)
		else $error("FCS run broken");

	// Status beats close the frame and carry no byte
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.check_status != ST_NONE |->
			out_beat.last_out && !out_beat.is_fcs && out_beat.out_byte == 8'h00)
		else $error("malformed status beat");

	// Too-short frames report no CRC values
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.check_status == ST_SHORT |->
			out_beat.computed_crc == 32'h0 && out_beat.received_fcs == 32'h0)
		else $error("too-short status with CRC values");

endmodule

bind crc32_frame_fcs_gen_check cfgc_checker u_cfgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.out_beat  (result_ch.payload)
);

@@ verif/fcs_checker.sv @@
// CRC helper package and the checker that predicts result beats and compares them.
package fcs_tb_pkg;
	import cfgc_pkg::*;

	// MSB-first CRC over one byte, one bit of feedback per step
	function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc,
			input logic [7:0] b);
		logic [31:0] acc;
		logic        fb;
		acc = crc;
		for (int i = 7; i >= 0; i--) begin
			fb  = acc[31] ^ b[i];
			acc = {acc[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
		end
		return acc;
	endfunction

	// FCS that a generator would append to this payload
	function automatic logic [31:0] frame_fcs(input logic [7:0] fr[$]);
		logic [31:0] acc;
		acc = CRC_INIT;
		foreach (fr[i]) acc = crc_shift_byte(acc, fr[i]);
		return acc ^ CRC_XOROUT;
	endfunction
endpackage

module fcs_checker import cfgc_pkg::*, fcs_tb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	cfgc_cfg_if    cfg_ch,
	cfgc_byte_if   byte_ch,
	cfgc_result_if result_ch,
	output int     fail_count,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic         verify_mode;
	logic [31:0]  crc_acc;
	logic [7:0]   tail [4];
	int           tail_fill;
	result_beat_t due_beats[$];
	int           errs = 0;

	assign fail_count = errs;

	function automatic void clear_frame();
		crc_acc   = CRC_INIT;
		tail      = '{default: '0};
		tail_fill = 0;
	endfunction

	// Work out the result beats that one accepted byte beat causes
	function automatic void forecast_beats(input byte_beat_t bt);
		result_beat_t r;
		logic [31:0]  fin;
		if (!verify_mode) begin
			crc_acc = crc_shift_byte(crc_acc, bt.data_byte);
			r = '0;
			r.out_byte = bt.data_byte;
			due_beats = {due_beats, r};
			if (bt.frame_end) begin
				fin = crc_acc ^ CRC_XOROUT;
				for (int k = 3; k >= 0; k--) begin
					r = '0;
					r.out_byte = fin[8*k +: 8];
					r.is_fcs   = 1'b1;
					if (k == 0) begin
						r.last_out     = 1'b1;
						r.computed_crc = fin;
					end
					due_beats = {due_beats, r};
				end
				clear_frame();
			end
		end else begin
			// oldest held byte enters the CRC once the delay line is full
			if (tail_fill >= 4) begin
				crc_acc = crc_shift_byte(crc_acc, tail[0]);
			end else begin
				tail_fill++;
			end
			tail = '{tail[1], tail[2], tail[3], bt.data_byte};
			if (bt.frame_end) begin
				r = '0;
				r.last_out = 1'b1;
				if (tail_fill < 4) begin
					r.check_status = ST_SHORT;
				end else begin
					r.received_fcs = {tail[0], tail[1], tail[2], tail[3]};
					r.computed_crc = crc_acc ^ CRC_XOROUT;
					r.check_status = (r.computed_crc == r.received_fcs) ? ST_VALID : ST_CORRUPT;
				end
				due_beats = {due_beats, r};
				clear_frame();
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			errs++;
		end
	endfunction

	function automatic void match_beat(input result_beat_t got);
		result_beat_t want;
		if (due_beats.size() == 0) begin
			$error("result beat with nothing due: out_byte 'h%0h last_out %0b status %0d",
				got.out_byte, got.last_out, got.check_status);
			errs++;
			return;
		end
		want = due_beats.pop_front();
		check_field("out_byte", want.out_byte, got.out_byte);
		check_field("is_fcs", want.is_fcs, got.is_fcs);
		check_field("last_out", want.last_out, got.last_out);
		check_field("check_status", want.check_status, got.check_status);
		check_field("computed_crc", want.computed_crc, got.computed_crc);
		check_field("received_fcs", want.received_fcs, got.received_fcs);
	endfunction

	// Sample all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verify_mode = 1'b0;
			clear_frame();
			due_beats.delete();
			pending <= 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) verify_mode = cfg_ch.data;
			if (byte_ch.valid && byte_ch.ready) forecast_beats(byte_ch.payload);
			if (result_ch.valid && result_ch.ready) match_beat(result_ch.payload);
			pending <= due_beats.size();
		end
	end
endmodule

@@ verif/tb_crc32_frame_fcs_gen_check.sv @@
// Testbench top: clock, reset, byte and config stimulus, result back-pressure, verdict.
module tb_crc32_frame_fcs_gen_check;
	timeunit 1ns;
	timeprecision 1ps;
	import cfgc_pkg::*;
	import fcs_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 400;
	// cycles to let the pipeline settle after the last due beat
	localparam int SETTLE       = 8;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	bit   calm = 1'b0;

	cfgc_cfg_if    cfg_ch();
	cfgc_byte_if   byte_ch();
	cfgc_result_if result_ch();

	crc32_frame_fcs_gen_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_ch    (cfg_ch),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	fcs_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_ch     (cfg_ch),
		.byte_ch    (byte_ch),
		.result_ch  (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** crc32_frame_fcs_gen_check: FAILED **");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int rand_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(13, 40);
		return $urandom_range(0, 12);
	endfunction

	// Result side back-pressure
	initial begin
		int hold;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			hold = gap_len();
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.payload <= '{data_byte: b, frame_end: last};
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic send_frame(input logic [7:0] fr[$], input bit closed);
		foreach (fr[i]) put_byte(fr[i], closed && (i == fr.size() - 1));
	endtask

	// Stop sending and wait until every due beat has come back
	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0]  fr[$];
		logic [31:0] fcs;
		logic        mode_now;
		int          sent;
		int          nframes;
		int          kind;
		int          n;
		int          j;
		bit          closed;

		arst_n          <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.data     <= 1'b0;
		byte_ch.valid   <= 1'b0;
		byte_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Generate mode: byte extremes, then a one-byte frame
		write_mode(1'b0);
		send_frame('{8'h00, 8'hFF, 8'h55, 8'hAA}, 1'b1);
		send_frame('{8'hFF}, 1'b1);
		drain();

		// Verify mode: too short, FCS with empty payload, good frame, corrupted frame
		write_mode(1'b1);
		send_frame('{8'h5A}, 1'b1);
		send_frame('{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
		fr = '{8'hC3};
		fcs = frame_fcs(fr);
		for (int k = 3; k >= 0; k--) fr = {fr, fcs[8*k +: 8]};
		send_frame(fr, 1'b1);
		send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);

		// Mode switch inside a frame, both directions
		send_frame('{8'h81, 8'h7E}, 1'b0);
		drain();
		write_mode(1'b0);
		send_frame('{8'hE7}, 1'b1);
		send_frame('{8'h01, 8'h80}, 1'b0);
		drain();
		write_mode(1'b1);
		send_frame('{8'h3C}, 1'b1);
		drain();

		// Random phases, one mode setting each
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode_now = $urandom_range(0, 1);
			calm     = ($urandom_range(0, 3) == 0);
			write_mode(mode_now);
			nframes = $urandom_range(1, 8);
			for (int f = 0; f < nframes; f++) begin
				fr.delete();
				kind = $urandom_range(0, 99);
				n    = rand_len();
				repeat (n) fr = {fr, 8'($urandom_range(0, 255))};
				if (mode_now && kind < 80) begin
					fcs = frame_fcs(fr);
					for (int k = 3; k >= 0; k--) fr = {fr, fcs[8*k +: 8]};
					// some frames get one bit flipped somewhere
					if (kind >= 65) begin
						j = $urandom_range(0, fr.size() - 1);
						fr[j] = fr[j] ^ (8'h01 << $urandom_range(0, 7));
					end
				end else if (fr.size() == 0) begin
					fr = {fr, 8'($urandom_range(0, 255))};
				end
				// occasionally leave the last frame open across the mode change
				closed = !((f == nframes - 1) && ($urandom_range(0, 9) == 0));
				send_frame(fr, closed);
				sent += fr.size();
			end
			drain();
		end
		calm = 1'b0;
		drain();

		if (fail_count == 0) begin
			$display("** crc32_frame_fcs_gen_check: PASSED **");
		end else begin
			$display("** crc32_frame_fcs_gen_check: FAILED **");
		end
		$finish;
	end
endmodule
